// ----- rtl/espc_pkg.sv -----
// Shared constants and types for the equal-sum partition checker.
package espc_pkg;

    // Default for the highest set total that is still checked.
    localparam int SUM_LIMIT_DEFAULT  = 1024;
    // Default width of one set element.
    localparam int VALUE_BITS_DEFAULT = 8;
    // Entries in the queue between the front and back ends; a power of two.
    localparam int QUEUE_DEPTH        = 2;

    // Control flags that travel with each element through the queue.
    typedef struct packed {
        logic last;     // final element of the set
        logic tracked;  // element is non-zero and can reach a tracked sum
    } elem_ctl_t;

    localparam int ELEM_CTL_BITS = $bits(elem_ctl_t);

    // Fill status of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- rtl/equal_sum_partition_check.sv -----
// Top level of the equal-sum partition checker: front end, queue and back end.
// Throughput: one element beat per cycle; only a last element waits, and only while the
// previous result is held by a stalled output. Input beats stall once the queue is full.
// Path: an accepted input beat is written into the queue; the back end takes it from there,
// and a last element sets the result register, so the result is valid from the edge it is taken.
// Reset (asynchronous, active low): empty queue, bitset at sum zero, total cleared, no result.
module equal_sum_partition_check #(
    parameter int SUM_LIMIT  = espc_pkg::SUM_LIMIT_DEFAULT,
    parameter int VALUE_BITS = espc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] element_value,
    input  logic                  is_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  possible,
    output logic                  overflow
);
    import espc_pkg::*;

    localparam int QW = VALUE_BITS + ELEM_CTL_BITS;

    // Signals between the front end, the queue and the back end.
    logic                  q_push;
    logic [VALUE_BITS-1:0] q_push_value;
    elem_ctl_t             q_push_ctl;
    logic                  q_pop;
    logic [QW-1:0]         q_pop_data;
    logic [VALUE_BITS-1:0] q_pop_value;
    elem_ctl_t             q_pop_ctl;
    queue_status_t         q_status;

    // The front end only classifies; every beat it accepts goes straight into the queue.
    espc_front #(
        .SUM_LIMIT  (SUM_LIMIT),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .element_value (element_value),
        .is_last       (is_last),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_value       (q_push_value),
        .q_ctl         (q_push_ctl)
    );

    // The queue lets input beats keep arriving while a result waits at the output.
    espc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({q_push_ctl, q_push_value}),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    assign q_pop_value = q_pop_data[VALUE_BITS-1:0];
    assign q_pop_ctl   = elem_ctl_t'(q_pop_data[QW-1:VALUE_BITS]);

    // The back end applies one element per cycle (a last one waits on a stalled result): a shift-OR
    // over the bitset and an add into the saturating total. The result register sits at its output.
    espc_back #(
        .SUM_LIMIT  (SUM_LIMIT),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_avail   (!q_status.empty),
        .q_value   (q_pop_value),
        .q_ctl     (q_pop_ctl),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .possible  (possible),
        .overflow  (overflow)
    );

    // An overflowed set can never be reported as splittable.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(possible && overflow))
        else $error("possible reported together with overflow");

    // A new result appears only after the back end took a last element.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_pop && q_pop_ctl.last))
        else $error("result beat without a last element");

    // The back end never takes an element from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");

endmodule

// ----- rtl/espc_queue.sv -----
// Short first-in first-out queue that decouples the front end from the back end.
module espc_queue #(
    parameter int WIDTH = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output espc_pkg::queue_status_t status
);
    import espc_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [WIDTH-1:0] entries_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [PW:0]      count_reg;
    logic [PW:0]      count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ----- rtl/espc_front.sv -----
// Front end: takes input beats and classifies each element for the back end.
module espc_front #(
    parameter int SUM_LIMIT  = espc_pkg::SUM_LIMIT_DEFAULT,
    parameter int VALUE_BITS = espc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [VALUE_BITS-1:0]   element_value,
    input  logic                    is_last,
    input  espc_pkg::queue_status_t q_status,
    output logic                    q_push,
    output logic [VALUE_BITS-1:0]   q_value,
    output espc_pkg::elem_ctl_t     q_ctl
);
    import espc_pkg::*;

    localparam int HALF = SUM_LIMIT / 2;
    localparam int CW   = ((VALUE_BITS > 17) ? VALUE_BITS : 17) + 1;

    // An element only moves the bitset when it is non-zero and no larger than half the limit.
    always_comb
    begin
        in_stall      = q_status.full;
        q_push        = in_valid && !q_status.full;
        q_value       = element_value;
        q_ctl.last    = is_last;
        q_ctl.tracked = (element_value != '0) && (CW'(element_value) <= CW'(HALF));
    end

endmodule

// ----- rtl/espc_back.sv -----
// Back end: updates the reachable-sum bitset and running total, and forms the result.
module espc_back #(
    parameter int SUM_LIMIT  = espc_pkg::SUM_LIMIT_DEFAULT,
    parameter int VALUE_BITS = espc_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_avail,
    input  logic [VALUE_BITS-1:0] q_value,
    input  espc_pkg::elem_ctl_t   q_ctl,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  possible,
    output logic                  overflow
);
    import espc_pkg::*;

    localparam int HALF = SUM_LIMIT / 2;
    localparam int TW   = $clog2(SUM_LIMIT + 2);
    localparam int SW   = ((TW > VALUE_BITS) ? TW : VALUE_BITS) + 1;
    localparam int IW   = $clog2(HALF + 1);
    localparam logic [HALF:0] REACH_INIT = (HALF+1)'(1);

    logic [HALF:0]           reach_reg;
    logic [HALF:0]           reach_next;
    logic [TW-1:0]           total_reg;
    logic [TW-1:0]           total_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    possible_reg;
    logic                    possible_next;
    logic                    overflow_reg;
    logic                    overflow_next;

    logic                    fire;
    logic [SW-1:0]           sum_wide;
    logic                    sum_over;
    logic                    ovf_new;
    logic [TW-1:0]           total_new;
    logic [SW-1:0]           half_sum;
    logic [SW-1:0]           diff;
    logic [VALUE_BITS-1:0]   shamt;
    logic                    hit_direct;
    logic                    hit_shift;

    always_comb
    begin
        // A last element needs the result register free, or freed in this cycle.
        fire     = q_avail && (!q_ctl.last || !out_valid_reg || !out_stall);
        sum_wide = SW'(total_reg) + SW'(q_value);
        sum_over = sum_wide > SW'(SUM_LIMIT);
        ovf_new  = ovf_reg || sum_over;
        total_new = sum_over ? TW'(SUM_LIMIT + 1) : sum_wide[TW-1:0];
        half_sum = SW'(total_new) >> 1;
        shamt    = q_ctl.tracked ? q_value : '0;

        // Half the new total is reachable if it already was, or if it is reached
        // from an old sum by adding this element.
        hit_direct = 1'b0;
        hit_shift  = 1'b0;
        diff       = half_sum - SW'(q_value);
        if (half_sum <= SW'(HALF))
        begin
            hit_direct = reach_reg[half_sum[IW-1:0]];
            if (q_ctl.tracked && (SW'(q_value) <= half_sum))
            begin
                hit_shift = reach_reg[diff[IW-1:0]];
            end
        end

        reach_next     = reach_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        possible_next  = possible_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (fire)
        begin
            if (q_ctl.last)
            begin
                reach_next     = REACH_INIT;
                total_next     = '0;
                ovf_next       = 1'b0;
                possible_next  = !ovf_new && !total_new[0] && (hit_direct || hit_shift);
                overflow_next  = ovf_new;
                out_valid_next = 1'b1;
            end
            else
            begin
                reach_next = reach_reg | (reach_reg << shamt);
                total_next = total_new;
                ovf_next   = ovf_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg     <= REACH_INIT;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            reach_reg     <= reach_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        possible_reg <= possible_next;
        overflow_reg <= overflow_next;
    end

    assign q_pop     = fire;
    assign out_valid = out_valid_reg;
    assign possible  = possible_reg;
    assign overflow  = overflow_reg;

endmodule

// ----- tb/equal_sum_partition_check_test.sv -----
// Self-checking testbench for the equal-sum partition checker.
module equal_sum_partition_check_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_LIMIT  = espc_pkg::SUM_LIMIT_DEFAULT;
    localparam int VALUE_BITS = espc_pkg::VALUE_BITS_DEFAULT;
    localparam int HALF_SUM   = SUM_LIMIT / 2;
    localparam int MAX_VALUE  = (1 << VALUE_BITS) - 1;

    // Number of element beats after which the random part stops.
    localparam int ELEMENT_TARGET = 1150;
    // Cycles for which the receiver refuses results during the hold-off phase.
    localparam int HOLD_OFF_CYCLES = 300;
    // Watchdog bound on the whole run; this leaves ample margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [VALUE_BITS-1:0] element_t;

    // Keeps its own copy of the subset-sum bitset, the running total and the
    // overflow flag, and queues one verdict per set in the order the sets end.
    class partition_scoreboard;
        typedef struct packed {
            logic possible;
            logic overflow;
        } verdict_t;

        logic [HALF_SUM:0] reach;
        int unsigned       total;
        bit                total_over;
        verdict_t          verdict_q[$];
        int                errors;

        function new();
            errors = 0;
            clear_set();
        endfunction

        function void clear_set();
            reach      = '0;
            reach[0]   = 1'b1;
            total      = 0;
            total_over = 1'b0;
        endfunction

        // Fold one accepted element into the set; on the last element queue
        // the verdict and start afresh.
        function void note_element(element_t value, logic last);
            verdict_t v;
            if (value != 0 && value <= HALF_SUM)
                reach = reach | (reach << value);
            total = total + value;
            if (total > SUM_LIMIT) begin
                total      = SUM_LIMIT + 1;
                total_over = 1'b1;
            end
            if (last) begin
                v.overflow = total_over;
                v.possible = !total_over && (total % 2 == 0) && reach[total / 2];
                verdict_q = {verdict_q, v};
                clear_set();
            end
        endfunction

        function void check_result(logic possible, logic overflow);
            verdict_t v;
            if (verdict_q.size() == 0) begin
                $display("%0t: result beat with no set pending, possible=%b overflow=%b",
                         $time, possible, overflow);
                errors++;
                return;
            end
            v = verdict_q.pop_front();
            if (possible !== v.possible) begin
                $display("%0t: possible mismatch, expected %b, actual %b",
                         $time, v.possible, possible);
                errors++;
            end
            if (overflow !== v.overflow) begin
                $display("%0t: overflow mismatch, expected %b, actual %b",
                         $time, v.overflow, overflow);
                errors++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    element_t element_value = '0;
    logic     is_last = 1'b0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    logic     possible;
    logic     overflow;

    partition_scoreboard sb = new();

    int elements_sent = 0;
    int cycles = 0;
    // Raised by the sender to ask the receiver for one long hold-off.
    bit hold_request = 1'b0;

    equal_sum_partition_check #(
        .SUM_LIMIT  (SUM_LIMIT),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .element_value (element_value),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .possible      (possible),
        .overflow      (overflow)
    );

    always #5 clk = ~clk;

    // Watchdog: a run that hangs is a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("equal_sum_partition_check test failed");
            $finish;
        end
    end

    // Every result beat is checked against the oldest outstanding verdict.
    // Values read here are those from before the edge, so the handshake is
    // judged exactly as the block sees it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(possible, overflow);
    end

    // Receiver. Mostly short runs of stall mixed with longer free runs, now and
    // then a long stall, and once a very long hold-off on request so that the
    // block fills up and pushes back on its input. Each pass makes exactly one
    // assignment to out_stall and then waits on the clock.
    initial
    begin
        int pick;
        int run_len;
        @(posedge clk);
        forever begin
            if (hold_request) begin
                out_stall <= 1'b1;
                for (int c = 0; c < HOLD_OFF_CYCLES; c++)
                    @(posedge clk);
                hold_request = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    out_stall <= 1'b0;
                    run_len = $urandom_range(1, 20);
                end else if (pick < 92) begin
                    out_stall <= 1'b1;
                    run_len = $urandom_range(1, 3);
                end else begin
                    out_stall <= 1'b1;
                    run_len = $urandom_range(10, 60);
                end
                repeat (run_len) @(posedge clk);
            end
        end
    end

    // Offer one element beat and wait until it is taken. The caller is always
    // at a rising edge, and this task returns at one. After the beat an idle gap
    // of random length may follow; in a back-to-back stretch there is none.
    task automatic send_element(input element_t value, input logic last, input bit back_to_back);
        int gap;
        int pick;
        in_valid      <= 1'b1;
        element_value <= value;
        is_last       <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_element(value, last);
        elements_sent++;
        gap = 0;
        if (!back_to_back) begin
            pick = $urandom_range(0, 99);
            if (pick >= 60 && pick < 92)
                gap = $urandom_range(1, 3);
            else if (pick >= 92)
                gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            // The payload wanders while nothing is offered; the block must ignore it.
            in_valid      <= 1'b0;
            element_value <= element_t'($urandom);
            is_last       <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_set(input element_t values[$], input bit back_to_back);
        foreach (values[i])
            send_element(values[i], i == values.size() - 1, back_to_back);
    endtask

    // Stop offering and wait until every queued verdict has been matched.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Build one random set. Mirrored sets hold every value twice, so they always
    // split evenly; the others give a spread of odd totals, unreachable halves
    // and overflowing totals.
    task automatic random_set(output element_t values[$], input int max_len);
        int      kind;
        int      len;
        int      j;
        element_t v;
        element_t tmp;
        values = {};
        kind = $urandom_range(0, 9);
        len  = $urandom_range(1, max_len);
        if (kind < 3) begin
            for (int i = 0; i < (len + 1) / 2; i++) begin
                v = element_t'($urandom_range(0, 60));
                values = {values, v, v};
            end
            for (int i = values.size() - 1; i > 0; i--) begin
                j         = $urandom_range(0, i);
                tmp       = values[i];
                values[i] = values[j];
                values[j] = tmp;
            end
        end else if (kind < 6) begin
            for (int i = 0; i < len; i++)
                values = {values, element_t'($urandom_range(0, 15))};
        end else if (kind < 9) begin
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 7))
                    0:       values = {values, element_t'(0)};
                    1:       values = {values, element_t'(MAX_VALUE)};
                    default: values = {values, element_t'($urandom)};
                endcase
            end
        end else begin
            // Long run of large values: the total can go over the limit part way
            // through, and further elements then arrive after the overflow.
            len = $urandom_range(6, 12);
            for (int i = 0; i < len; i++)
                values = {values, element_t'($urandom_range(150, MAX_VALUE))};
        end
    endtask

    // Random sets until the element count reaches the given mark. Roughly one
    // set in five is sent without any idle cycles between its beats.
    task automatic random_sets_until(input int mark);
        element_t values[$];
        while (elements_sent < mark) begin
            random_set(values, 10);
            send_set(values, $urandom_range(0, 4) == 0);
        end
    endtask

    initial
    begin
        element_t values[$];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets. A lone zero splits trivially; a lone non-zero cannot.
        send_set('{element_t'(0)}, 1'b0);
        send_set('{element_t'(1)}, 1'b0);
        send_set('{element_t'(MAX_VALUE)}, 1'b0);
        send_set('{element_t'(MAX_VALUE), element_t'(MAX_VALUE)}, 1'b0);
        send_set('{element_t'(3), element_t'(1), element_t'(2)}, 1'b1);
        // Zero elements leave the reachable sums alone.
        send_set('{element_t'(0), element_t'(7), element_t'(0), element_t'(7)}, 1'b0);
        // Total exactly at the limit, with half of it reachable.
        send_set('{element_t'(255), element_t'(1), element_t'(255), element_t'(1),
                   element_t'(255), element_t'(1), element_t'(255), element_t'(1)}, 1'b1);
        // One over the limit: overflow is flagged and possible is forced low.
        send_set('{element_t'(255), element_t'(255), element_t'(255), element_t'(255),
                   element_t'(5)}, 1'b0);
        wait_drained();

        random_sets_until(400);

        // Long hold-off on the result side while short sets keep coming, so the
        // block runs out of room and stalls its input beats.
        hold_request = 1'b1;
        for (int s = 0; s < 30; s++) begin
            random_set(values, 2);
            send_set(values, 1'b1);
        end

        random_sets_until(800);

        // The sender pauses here until every outstanding verdict is back.
        wait_drained();

        random_sets_until(ELEMENT_TARGET);

        wait_drained();
        repeat (10) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("equal_sum_partition_check test passed");
        else
            $display("equal_sum_partition_check test failed");
        $finish;
    end

endmodule
